// ===== sv/rtcs_pkg.sv =====
// shared types, constants and the month table for the soft rtc calendar sync block
package rtcs_pkg;

   // millisecond ticks per second and its reciprocal for the elapsed-seconds divide
   localparam int unsigned TICKS_PER_SECOND = 1000;
   localparam int unsigned TPS_LOG2         = $clog2(TICKS_PER_SECOND);
   localparam int unsigned TPS_SHIFT        = 32 + TPS_LOG2;
   localparam int unsigned TPS_PROD_W       = TPS_SHIFT + 32;
   localparam logic [32:0] TPS_RECIP        =
      33'((((64'd1 << TPS_SHIFT) + 64'(TICKS_PER_SECOND) - 64'd1) / 64'(TICKS_PER_SECOND)));

   localparam logic        CMD_SYNC       = 1'b0;

   localparam logic [11:0] YEAR_BASE      = 12'd2000;
   localparam logic [8:0]  DAYS_PER_YEAR  = 9'd365;
   localparam logic [3:0]  MONTH_FIRST    = 4'd1;
   localparam logic [3:0]  MONTH_LAST     = 4'd12;
   localparam logic [3:0]  MONTH_FEB      = 4'd2;
   localparam logic [16:0] SECS_PER_DAY   = 17'd86400;
   localparam logic [11:0] SECS_PER_HOUR  = 12'd3600;
   localparam logic [5:0]  SECS_PER_MIN   = 6'd60;
   localparam logic [5:0]  MIN_PER_HOUR   = 6'd60;
   localparam logic [4:0]  HOURS_PER_DAY  = 5'd24;
   localparam logic [31:0] EPOCH_2000     = 32'd946684800;

   // exact reciprocal multipliers for 32-bit dividends
   localparam logic [31:0] DIV60_MULT     = 32'h88888889;
   localparam int unsigned DIV60_SHIFT    = 37;
   localparam logic [31:0] DIV3600_MULT   = 32'h91A2B3C5;
   localparam int unsigned DIV3600_SHIFT  = 43;
   // exact for 18-bit dividends
   localparam logic [17:0] DIV3_MULT      = 18'd174763;
   localparam int unsigned DIV3_SHIFT     = 19;

   typedef struct packed {
      logic        command;
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [31:0] tick_ms;
   } req_type;

   typedef struct packed {
      logic        valid_res;
      logic [31:0] epoch_seconds;
      logic [4:0]  now_hour;
      logic [5:0]  now_minute;
      logic [5:0]  now_second;
   } rsp_type;

   // current time handed from the epoch pipeline to the time-of-day split
   typedef struct packed {
      logic        valid_res;
      logic [31:0] secs;
   } secs_type;

   function automatic logic [8:0] days_before_month(input logic [3:0] idx);
      logic [8:0] d;
      case (idx)
         4'd0:    d = 9'd0;
         4'd1:    d = 9'd31;
         4'd2:    d = 9'd59;
         4'd3:    d = 9'd90;
         4'd4:    d = 9'd120;
         4'd5:    d = 9'd151;
         4'd6:    d = 9'd181;
         4'd7:    d = 9'd212;
         4'd8:    d = 9'd243;
         4'd9:    d = 9'd273;
         4'd10:   d = 9'd304;
         4'd11:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

// ===== sv/rtcs_epoch_calc.sv =====
// calendar to epoch conversion, clock base state and current-seconds pipeline
module rtcs_epoch_calc
   import rtcs_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  req_type  in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output secs_type out_data
);

   typedef struct packed {
      logic        is_sync;
      logic        valid_res;
      logic [31:0] days;
      logic [16:0] tod;
      logic [31:0] elapsed;
   } st2_type;

   typedef struct packed {
      logic        is_sync;
      logic        valid_res;
      logic [31:0] value;
   } st3_type;

   logic     s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic     s1_take, s2_take, s3_take, s4_take;
   req_type  s1_data_ff;
   st2_type  s2_data_ff, s2_data_in;
   st3_type  s3_data_ff, s3_data_in;
   secs_type s4_data_ff, s4_data_in;

   logic        synced_ff;
   logic [31:0] base_tick_ff, base_tick_in;
   logic [31:0] base_epoch_ff, base_epoch_in;
   logic        sync_s1_move, sync_s3_move;

   // a stage loads when it is empty or its content moves on
   assign s4_take  = !s4_valid_ff || out_ready;
   assign s3_take  = !s3_valid_ff || s4_take;
   assign s2_take  = !s2_valid_ff || s3_take;
   assign s1_take  = !s1_valid_ff || s2_take;
   assign in_ready = s1_take;

   // base tick and valid flag are read by queries in stage 1, base seconds in stage 3
   assign sync_s1_move  = s1_valid_ff && s2_take && (s1_data_ff.command == CMD_SYNC);
   assign sync_s3_move  = s3_valid_ff && s4_take && s3_data_ff.is_sync;
   assign base_tick_in  = s1_data_ff.tick_ms;
   assign base_epoch_in = s3_data_ff.value;

   // stage 1: day count, time of day, elapsed ticks
   always_comb begin
      logic [11:0] y_off;
      logic [3:0]  m_cl;
      logic [20:0] y_days;
      logic [12:0] y_p3;
      logic        leap_add;
      y_off = s1_data_ff.year - YEAR_BASE;
      if (s1_data_ff.month < MONTH_FIRST) begin
         m_cl = MONTH_FIRST;
      end else if (s1_data_ff.month > MONTH_LAST) begin
         m_cl = MONTH_LAST;
      end else begin
         m_cl = s1_data_ff.month;
      end
      y_days   = 21'(y_off) * 21'(DAYS_PER_YEAR);
      y_p3     = 13'(y_off) + 13'd3;
      leap_add = (m_cl > MONTH_FEB) && (y_off[1:0] == 2'b00);
      s2_data_in.is_sync   = (s1_data_ff.command == CMD_SYNC);
      s2_data_in.valid_res = (s1_data_ff.command == CMD_SYNC) || synced_ff;
      // day 0 wraps to one day before the first
      s2_data_in.days = 32'(y_days) + 32'(y_p3[12:2])
                      + 32'(days_before_month(m_cl - MONTH_FIRST))
                      + 32'(leap_add) + 32'(s1_data_ff.day) - 32'd1;
      s2_data_in.tod  = 17'(s1_data_ff.hour) * 17'(SECS_PER_HOUR)
                      + 17'(s1_data_ff.minute) * 17'(SECS_PER_MIN)
                      + 17'(s1_data_ff.second);
      s2_data_in.elapsed = s1_data_ff.tick_ms - base_tick_ff;
   end

   // stage 2: sync base in seconds, or whole seconds elapsed
   always_comb begin
      logic [TPS_PROD_W-1:0] prod;
      logic [31:0]           day_secs;
      day_secs = 32'(s2_data_ff.days * 32'(SECS_PER_DAY));
      prod     = TPS_PROD_W'(s2_data_ff.elapsed) * TPS_PROD_W'(TPS_RECIP);
      s3_data_in.is_sync   = s2_data_ff.is_sync;
      s3_data_in.valid_res = s2_data_ff.valid_res;
      if (s2_data_ff.is_sync) begin
         s3_data_in.value = day_secs + 32'(s2_data_ff.tod) + EPOCH_2000;
      end else begin
         s3_data_in.value = prod[TPS_SHIFT +: 32];
      end
   end

   // stage 3: current seconds, forced to zero before the first sync
   always_comb begin
      s4_data_in.valid_res = s3_data_ff.valid_res;
      if (!s3_data_ff.valid_res) begin
         s4_data_in.secs = 32'd0;
      end else if (s3_data_ff.is_sync) begin
         s4_data_in.secs = s3_data_ff.value;
      end else begin
         s4_data_in.secs = base_epoch_ff + s3_data_ff.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         s4_valid_ff   <= 1'b0;
         synced_ff     <= 1'b0;
         base_tick_ff  <= 32'd0;
         base_epoch_ff <= 32'd0;
      end else begin
         if (s1_take) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_take) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_take) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (s4_take) begin
            s4_valid_ff <= s3_valid_ff;
         end
         if (sync_s1_move) begin
            synced_ff    <= 1'b1;
            base_tick_ff <= base_tick_in;
         end
         if (sync_s3_move) begin
            base_epoch_ff <= base_epoch_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_take) begin
         s1_data_ff <= in_data;
      end
      if (s2_take) begin
         s2_data_ff <= s2_data_in;
      end
      if (s3_take) begin
         s3_data_ff <= s3_data_in;
      end
      if (s4_take) begin
         s4_data_ff <= s4_data_in;
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_data  = s4_data_ff;

endmodule

// ===== sv/rtcs_hms_split.sv =====
// splits epoch seconds into hour, minute and second of day
module rtcs_hms_split
   import rtcs_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  secs_type in_data,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);

   typedef struct packed {
      logic        valid_res;
      logic [31:0] secs;
      logic [26:0] q60;
      logic [20:0] q3600;
   } h1_type;

   typedef struct packed {
      logic        valid_res;
      logic [31:0] secs;
      logic [5:0]  sec;
      logic [5:0]  minute;
      logic [4:0]  q3600_lo;
      logic [4:0]  q24_lo;
   } h2_type;

   logic    h1_valid_ff, h2_valid_ff, out_valid_ff;
   logic    h1_take, h2_take, out_take;
   h1_type  h1_data_ff, h1_data_in;
   h2_type  h2_data_ff, h2_data_in;
   rsp_type out_data_ff, out_data_in;

   assign out_take = !out_valid_ff || rsp_ready;
   assign h2_take  = !h2_valid_ff || out_take;
   assign h1_take  = !h1_valid_ff || h2_take;
   assign in_ready = h1_take;

   // seconds / 60 and seconds / 3600 by reciprocal multiply
   always_comb begin
      logic [63:0] p60;
      logic [63:0] p3600;
      p60   = 64'(in_data.secs) * 64'(DIV60_MULT);
      p3600 = 64'(in_data.secs) * 64'(DIV3600_MULT);
      h1_data_in.valid_res = in_data.valid_res;
      h1_data_in.secs      = in_data.secs;
      h1_data_in.q60       = p60[DIV60_SHIFT +: 27];
      h1_data_in.q3600     = p3600[DIV3600_SHIFT +: 21];
   end

   // remainders are below 64, so six-bit arithmetic is exact; hours / 24 as (h / 8) / 3
   always_comb begin
      logic [11:0] sec_m;
      logic [11:0] min_m;
      logic [35:0] p3;
      sec_m = 12'(h1_data_ff.q60[5:0]) * 12'(SECS_PER_MIN);
      min_m = 12'(h1_data_ff.q3600[5:0]) * 12'(MIN_PER_HOUR);
      p3    = 36'(h1_data_ff.q3600[20:3]) * 36'(DIV3_MULT);
      h2_data_in.valid_res = h1_data_ff.valid_res;
      h2_data_in.secs      = h1_data_ff.secs;
      h2_data_in.sec       = h1_data_ff.secs[5:0] - sec_m[5:0];
      h2_data_in.minute    = h1_data_ff.q60[5:0] - min_m[5:0];
      h2_data_in.q3600_lo  = h1_data_ff.q3600[4:0];
      h2_data_in.q24_lo    = p3[DIV3_SHIFT +: 5];
   end

   always_comb begin
      logic [9:0] hr_m;
      hr_m = 10'(h2_data_ff.q24_lo) * 10'(HOURS_PER_DAY);
      out_data_in.valid_res     = h2_data_ff.valid_res;
      out_data_in.epoch_seconds = h2_data_ff.secs;
      out_data_in.now_hour      = h2_data_ff.q3600_lo - hr_m[4:0];
      out_data_in.now_minute    = h2_data_ff.minute;
      out_data_in.now_second    = h2_data_ff.sec;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h1_valid_ff  <= 1'b0;
         h2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (h1_take) begin
            h1_valid_ff <= in_valid;
         end
         if (h2_take) begin
            h2_valid_ff <= h1_valid_ff;
         end
         if (out_take) begin
            out_valid_ff <= h2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (h1_take) begin
         h1_data_ff <= h1_data_in;
      end
      if (h2_take) begin
         h2_data_ff <= h2_data_in;
      end
      if (out_take) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// ===== sv/soft_rtc_calendar_sync_top.sv =====
// top level of the soft rtc calendar sync block
// A sync transaction turns a 2000-2099 calendar date and time into Unix seconds and
// stores it with its millisecond tick; a query transaction returns that base plus the
// whole seconds elapsed since, with hour, minute and second of day, or all zeros before
// the first sync. Every transaction gives one result, in order. The block is a
// seven-stage pipeline (four stages for the epoch math, three for the time-of-day split,
// each multiplier followed by a register), so it takes one transaction per clock while
// results are taken at the output; the first stage loads at acceptance, and empty
// stages keep filling while a result waits at the output.
module soft_rtc_calendar_sync_top
   import rtcs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic     secs_valid;
   logic     secs_ready;
   secs_type secs_data;

   rtcs_epoch_calc u_epoch_calc (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (secs_valid),
      .out_ready (secs_ready),
      .out_data  (secs_data)
   );

   rtcs_hms_split u_hms_split (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (secs_valid),
      .in_ready  (secs_ready),
      .in_data   (secs_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== test/rtcs_result_monitor.sv =====
// result monitor for the soft rtc calendar sync block: predicts every response and compares it
module rtcs_result_monitor
   import rtcs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      mismatches,
   output int      pending,
   output int      sync_count,
   output int      query_count,
   output int      checked
);

   // days in the year before the first of each month, non-leap
   int unsigned month_start [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

   rsp_type     awaited [$];
   rsp_type     due;
   logic        clock_set;
   logic [31:0] base_secs;
   logic [31:0] base_ms;

   function automatic logic [31:0] date_to_unix(input req_type r);
      logic [11:0] yoff;
      logic [31:0] y;
      logic [31:0] m;
      logic [31:0] days;
      yoff = r.year - YEAR_BASE;
      y = 32'(yoff);
      m = 32'(r.month);
      if (m < 1) m = 1;
      if (m > 12) m = 12;
      days = y * 32'd365 + (y + 32'd3) / 32'd4 + month_start[m - 1];
      // every fourth year counts as leap, february has passed from march on
      if (m > 2 && y[1:0] == 2'b00) days = days + 32'd1;
      days = days + 32'(r.day) - 32'd1;
      return (days * 32'd24 + 32'(r.hour)) * 32'd3600 + 32'(r.minute) * 32'd60
             + 32'(r.second) + EPOCH_2000;
   endfunction

   function automatic rsp_type time_of_day(input logic [31:0] s);
      rsp_type res;
      res.valid_res     = 1'b1;
      res.epoch_seconds = s;
      res.now_hour      = 5'((s / 32'd3600) % 32'd24);
      res.now_minute    = 6'((s / 32'd60) % 32'd60);
      res.now_second    = 6'(s % 32'd60);
      return res;
   endfunction

   // updates the tracked clock state and returns the response this transaction should get
   function automatic rsp_type clock_response(input req_type r);
      rsp_type     res;
      logic [31:0] elapsed;
      res = '0;
      if (r.command == CMD_SYNC) begin
         base_secs = date_to_unix(r);
         base_ms   = r.tick_ms;
         clock_set = 1'b1;
         res = time_of_day(base_secs);
      end else if (clock_set) begin
         elapsed = r.tick_ms - base_ms;
         res = time_of_day(base_secs + elapsed / 32'(TICKS_PER_SECOND));
      end
      return res;
   endfunction

   task automatic flag_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d (0x%h), got %0d (0x%h)",
                  $time, name, want, want, got, got);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clock_set = 1'b0;
         base_secs = '0;
         base_ms   = '0;
         awaited.delete();
      end else begin
         if (req_valid && req_ready) begin
            awaited.push_back(clock_response(req_data));
            if (req_data.command == CMD_SYNC) sync_count++;
            else query_count++;
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited.size() == 0) begin
               mismatches++;
               $display("%0t: response with no transaction pending, expected none, got %h",
                        $time, rsp_data);
            end else begin
               due = awaited.pop_front();
               checked++;
               flag_field("valid_res", 32'(due.valid_res), 32'(rsp_data.valid_res));
               flag_field("epoch_seconds", due.epoch_seconds, rsp_data.epoch_seconds);
               flag_field("now_hour", 32'(due.now_hour), 32'(rsp_data.now_hour));
               flag_field("now_minute", 32'(due.now_minute), 32'(rsp_data.now_minute));
               flag_field("now_second", 32'(due.now_second), 32'(rsp_data.now_second));
            end
         end
      end
      pending = awaited.size();
   end

endmodule

// ===== test/tb_soft_rtc_calendar_sync_top.sv =====
// testbench top for the soft rtc calendar sync block: stimulus, flow control and verdict
module tb_soft_rtc_calendar_sync_top;
   import rtcs_pkg::*;

   localparam logic CMD_QUERY    = 1'b1;
   localparam int   RANDOM_ITEMS = 1150;
   localparam int   DRAIN_CYCLES = 30;
   localparam int   MAX_IDLE     = 12;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   int mismatches;
   int pending;
   int sync_count;
   int query_count;
   int checked;

   logic        steady;
   logic [31:0] clock_ms;

   soft_rtc_calendar_sync_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   rtcs_result_monitor monitor (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .mismatches  (mismatches),
      .pending     (pending),
      .sync_count  (sync_count),
      .query_count (query_count),
      .checked     (checked)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   initial begin
      #5_000_000;
      $display("%0t: run did not finish in time", $time);
      $display("Simulation FAILED");
      $finish;
   end

   function automatic int unsigned idle_gap();
      return steady ? 0 : $urandom_range(0, MAX_IDLE);
   endfunction

   function automatic req_type make_req(input logic cmd, input logic [11:0] yr,
                                        input logic [3:0] mo, input logic [4:0] dy,
                                        input logic [4:0] hr, input logic [5:0] mi,
                                        input logic [5:0] se, input logic [31:0] tk);
      req_type r;
      r.command = cmd;
      r.year    = yr;
      r.month   = mo;
      r.day     = dy;
      r.hour    = hr;
      r.minute  = mi;
      r.second  = se;
      r.tick_ms = tk;
      return r;
   endfunction

   // syncs mostly get well-formed dates, other items raw field noise; the tick mostly moves forward
   function automatic req_type random_item();
      req_type r;
      r.command = ($urandom_range(0, 9) < 3) ? CMD_SYNC : CMD_QUERY;
      if (r.command == CMD_SYNC && $urandom_range(0, 9) < 8) begin
         r.year   = 12'($urandom_range(2000, 2099));
         r.month  = 4'($urandom_range(1, 12));
         r.day    = 5'($urandom_range(1, 31));
         r.hour   = 5'($urandom_range(0, 23));
         r.minute = 6'($urandom_range(0, 59));
         r.second = 6'($urandom_range(0, 59));
      end else begin
         r.year   = 12'($urandom);
         r.month  = 4'($urandom);
         r.day    = 5'($urandom);
         r.hour   = 5'($urandom);
         r.minute = 6'($urandom);
         r.second = 6'($urandom);
      end
      case ($urandom_range(0, 3))
         0:       clock_ms = clock_ms + $urandom_range(0, 999);
         1:       clock_ms = clock_ms + $urandom_range(0, 100000);
         2:       clock_ms = clock_ms + $urandom_range(0, 1 << 24);
         default: clock_ms = $urandom;
      endcase
      r.tick_ms = clock_ms;
      return r;
   endfunction

   task automatic send_item(input req_type r);
      int unsigned gap;
      gap = idle_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   // response side: random stall before each transaction, ready held until it is taken
   initial begin
      int unsigned stall;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         stall = idle_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      steady    = 1'b0;
      clock_ms  = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // queries before any sync must read all zeros
      send_item(make_req(CMD_QUERY, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 32'd0));
      send_item(make_req(CMD_QUERY, '1, '1, '1, '1, '1, '1, '1));
      send_item(make_req(CMD_SYNC, 12'd2000, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 32'd0));
      send_item(make_req(CMD_QUERY, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 32'd999));
      send_item(make_req(CMD_QUERY, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 32'd1000));
      send_item(make_req(CMD_SYNC, 12'd2099, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, '1));
      // tick wraps past zero, then the largest elapsed count
      send_item(make_req(CMD_QUERY, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 32'd999));
      send_item(make_req(CMD_QUERY, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 32'hFFFF_FFFE));
      // leap years and the day after february
      send_item(make_req(CMD_SYNC, 12'd2024, 4'd2, 5'd29, 5'd12, 6'd30, 6'd45, 32'd5));
      send_item(make_req(CMD_SYNC, 12'd2024, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0, 32'd6));
      send_item(make_req(CMD_SYNC, 12'd2023, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0, 32'd7));
      send_item(make_req(CMD_SYNC, 12'd2000, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0, 32'd8));
      // month clamping, day zero, oversized time fields
      send_item(make_req(CMD_SYNC, 12'd2001, 4'd0, 5'd15, 5'd1, 6'd2, 6'd3, 32'd9));
      send_item(make_req(CMD_SYNC, 12'd2001, 4'd13, 5'd15, 5'd1, 6'd2, 6'd3, 32'd10));
      send_item(make_req(CMD_SYNC, 12'd2002, 4'd15, 5'd31, 5'd4, 6'd5, 6'd6, 32'd11));
      send_item(make_req(CMD_SYNC, 12'd2010, 4'd6, 5'd0, 5'd0, 6'd0, 6'd0, 32'd12));
      send_item(make_req(CMD_SYNC, 12'd2010, 4'd6, 5'd10, 5'd31, 6'd63, 6'd63, 32'd13));
      // years outside the century wrap the offset
      send_item(make_req(CMD_SYNC, 12'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 32'd14));
      send_item(make_req(CMD_SYNC, '1, '1, '1, '1, '1, '1, 32'd0));
      send_item(make_req(CMD_QUERY, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, '1));
      send_item(make_req(CMD_SYNC, 12'd1999, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 32'd15));
      send_item(make_req(CMD_SYNC, 12'd2100, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 32'd16));
      send_item(make_req(CMD_SYNC, 12'd2038, 4'd1, 5'd19, 5'd3, 6'd14, 6'd7, 32'd123456));
      send_item(make_req(CMD_QUERY, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 32'd3723456));

      clock_ms = 32'd3723456;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         // every so often a stretch with no idling on either side
         if (i % 50 == 0) steady = ($urandom_range(0, 3) == 0);
         send_item(random_item());
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d sync and %0d query transactions, %0d responses compared",
               sync_count, query_count, checked);
      if (mismatches == 0 && pending == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches, %0d responses missing", mismatches, pending);
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
